FILE: rtl/wavetable_sound_generator_assert.svh
// assertion macros for the wavetable sound generator
`ifndef WAVETABLE_SOUND_GENERATOR_ASSERT_SVH
`define WAVETABLE_SOUND_GENERATOR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define WSG_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define WSG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/wsg_pkg.sv
// package: constants, item types and helpers of the wavetable sound generator
package wsg_pkg;

	localparam int CHANNELS    = 5;
	localparam int WAVE_LENGTH = 32;
	localparam int WAVEFORMS   = 4;

	localparam int CH_W  = $clog2(CHANNELS);
	localparam int POS_W = $clog2(WAVE_LENGTH);

	// register file map
	localparam int MIRROR_LO   = 'h90;
	localparam int MIRROR_HI   = 'h9F;
	localparam int MIRROR_OFS  = 'h10;
	localparam int PERIOD_BASE = 'h80;
	localparam int VOLUME_BASE = 'h8A;
	localparam int ENABLE_ADDR = 'h8F;

	localparam int SAMPLE_MIN = -32768;
	localparam int SAMPLE_MAX = 32767;

	// signed sum of all channel levels
	localparam int ACC_W  = 15;
	localparam int PROD_W = 24;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic {
		CFG_CLOCK_DIVIDER = 1'b0,
		CFG_OUTPUT_GAIN   = 1'b1
	} cfg_index_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  address;
		logic [7:0]  write_data;
	} req_t;

	typedef struct packed {
		logic [7:0]         read_data;
		logic               sample_valid;
		logic signed [15:0] sample;
	} rsp_t;

	// fold the mirror window onto the control registers
	function automatic logic [7:0] map_address(input logic [7:0] a);
		if (int'(a) >= MIRROR_LO && int'(a) <= MIRROR_HI)
			return 8'(int'(a) - MIRROR_OFS);
		return a;
	endfunction

	// byte address of a channel's current wave sample
	function automatic logic [7:0] sample_address(input logic [CH_W-1:0] ch,
			input logic [POS_W-1:0] pos);
		int w;
		if (ch == '0)
			w = 0;
		else if (int'(ch) >= CHANNELS - 1)
			w = WAVEFORMS - 1;
		else
			w = int'(ch);
		if (w > WAVEFORMS - 1)
			w = WAVEFORMS - 1;
		return 8'((w * WAVE_LENGTH + int'(pos)) & 'hFF);
	endfunction

endpackage

FILE: rtl/wavetable_sound_generator.sv
// top level: wavetable sound generator with register file, channel sequencer and mixer
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------
//  req     | req_valid/req_stall  | cmd, address, write_data
//  rsp     | rsp_valid/rsp_stall  | read_data, sample_valid, sample
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// after reset a clearing pass zeroes the 256-byte register file, with req_stall high
// a write goes to the done state, a read first to the read state (one registered memory read)
// a tick runs through the states in order: per channel one advance step
// and one multiply step on the shared multiplier, then one mix step on the same multiplier
// a finished item waits in the output register while the next item is accepted;
// rsp_stall only holds the sequencer when a second result is ready and the first is still held
module wavetable_sound_generator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  wsg_pkg::req_t        req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output wsg_pkg::rsp_t        rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  wsg_pkg::cfg_index_t  cfg_index,
	input  logic [15:0]          cfg_data
);

	`include "wavetable_sound_generator_assert.svh"

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_ADV,
		S_MUL,
		S_MIX,
		S_DONE
	} state_t;

	state_t state_q;

	// register file, bytes 0x90-0x9f are never used because of the mirror
	logic [7:0] mem [256];
	logic [7:0] mem_rd_q;
	logic [7:0] rd_addr;
	logic [7:0] clr_q;

	// shadow copies of the control bytes, read by the channel sequencer
	logic [7:0]             per_lo_q [wsg_pkg::CHANNELS];
	logic [3:0]             per_hi_q [wsg_pkg::CHANNELS];
	logic [3:0]             vol_q    [wsg_pkg::CHANNELS];
	logic [wsg_pkg::CHANNELS-1:0] en_q;

	// channel state
	logic [11:0]               phase_q [wsg_pkg::CHANNELS];
	logic [wsg_pkg::POS_W-1:0] pos_q   [wsg_pkg::CHANNELS];
	logic [wsg_pkg::CH_W-1:0]  ch_q;
	logic signed [wsg_pkg::ACC_W-1:0] acc_q;
	logic [15:0]               pre_q;

	// configuration
	logic [15:0] div_q;
	logic [6:0]  gain_q;

	wsg_pkg::rsp_t res_q;
	wsg_pkg::rsp_t out_q;
	logic          out_valid_q;

	logic        req_acc;
	logic [7:0]  req_maddr;
	logic [11:0] period;
	logic        active;
	logic [11:0] ph_inc;
	logic        ph_wrap;
	logic [wsg_pkg::POS_W-1:0] pos_next;

	logic signed [15:0]                mul_a;
	logic signed [7:0]                 mul_b;
	logic signed [wsg_pkg::PROD_W-1:0] prod;
	logic signed [15:0]                sat;
	logic [16:0]                       pre_inc;
	logic                              emit;
	logic                              out_free;

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign req_maddr = wsg_pkg::map_address(req.address);
	assign cfg_ready = 1'b1;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;
	assign out_free  = !out_valid_q || !rsp_stall;

	// current channel's step
	assign period   = {per_hi_q[ch_q], per_lo_q[ch_q]};
	assign active   = en_q[ch_q] && (vol_q[ch_q] != 4'd0) && (period != 12'd0);
	assign ph_inc   = phase_q[ch_q] + 12'd1;
	assign ph_wrap  = (ph_inc >= period);
	assign pos_next = ph_wrap ? pos_q[ch_q] + 1'b1 : pos_q[ch_q];

	// read address: bus read at accept, else the sample of the channel being advanced
	always_comb begin
		if (state_q == S_IDLE)
			rd_addr = req_maddr;
		else
			rd_addr = wsg_pkg::sample_address(ch_q, pos_next);
	end

	// shared multiplier: sample times volume, or channel sum times gain
	always_comb begin
		if (state_q == S_MIX) begin
			mul_a = {{(16 - wsg_pkg::ACC_W){acc_q[wsg_pkg::ACC_W-1]}}, acc_q};
			mul_b = {1'b0, gain_q};
		end else begin
			mul_a = {{8{mem_rd_q[7]}}, mem_rd_q};
			mul_b = {4'd0, vol_q[ch_q]};
		end
	end

	assign prod = mul_a * mul_b;

	// clip to 16 bits signed
	always_comb begin
		if (prod < wsg_pkg::PROD_W'(wsg_pkg::SAMPLE_MIN))
			sat = 16'sh8000;
		else if (prod > wsg_pkg::PROD_W'(wsg_pkg::SAMPLE_MAX))
			sat = 16'sh7FFF;
		else
			sat = prod[15:0];
	end

	// divider zero behaves like one, the 17-bit count always passes it
	assign pre_inc = {1'b0, pre_q} + 17'd1;
	assign emit    = (pre_inc >= {1'b0, div_q});

	// register file memory
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR)
			mem[clr_q] <= 8'd0;
		else if (req_acc && req.cmd == wsg_pkg::CMD_WRITE)
			mem[req_maddr] <= req.write_data;
		mem_rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= 8'd0;
			ch_q        <= '0;
			acc_q       <= '0;
			pre_q       <= 16'd0;
			div_q       <= 16'd1;
			gain_q      <= 7'd1;
			en_q        <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < wsg_pkg::CHANNELS; c++) begin
				per_lo_q[c] <= 8'd0;
				per_hi_q[c] <= 4'd0;
				vol_q[c]    <= 4'd0;
				phase_q[c]  <= 12'd0;
				pos_q[c]    <= '0;
			end
		end else begin
			// configuration is taken in any state
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					wsg_pkg::CFG_CLOCK_DIVIDER: div_q  <= cfg_data;
					wsg_pkg::CFG_OUTPUT_GAIN:   gain_q <= cfg_data[6:0];
					default: ;
				endcase
			end

			// output register empties when its item is taken and nothing refills it
			if (out_valid_q && !rsp_stall && state_q != S_DONE)
				out_valid_q <= 1'b0;

			// control bytes mirrored into the shadow registers
			if (req_acc && req.cmd == wsg_pkg::CMD_WRITE) begin
				for (int c = 0; c < wsg_pkg::CHANNELS; c++) begin
					if (req_maddr == 8'(wsg_pkg::PERIOD_BASE + 2 * c))
						per_lo_q[c] <= req.write_data;
					if (req_maddr == 8'(wsg_pkg::PERIOD_BASE + 2 * c + 1))
						per_hi_q[c] <= req.write_data[3:0];
					if (req_maddr == 8'(wsg_pkg::VOLUME_BASE + c))
						vol_q[c] <= req.write_data[3:0];
				end
				if (req_maddr == 8'(wsg_pkg::ENABLE_ADDR))
					en_q <= req.write_data[wsg_pkg::CHANNELS-1:0];
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 8'd1;
					if (clr_q == 8'hFF)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_acc) begin
						res_q.read_data    <= 8'd0;
						res_q.sample_valid <= 1'b0;
						res_q.sample       <= 16'sd0;
						unique case (req.cmd)
							wsg_pkg::CMD_READ: state_q <= S_READ;
							wsg_pkg::CMD_TICK: begin
								ch_q    <= '0;
								acc_q   <= '0;
								state_q <= S_ADV;
							end
							wsg_pkg::CMD_WRITE,
							wsg_pkg::CMD_NONE: state_q <= S_DONE;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_READ: begin
					res_q.read_data <= mem_rd_q;
					state_q         <= S_DONE;
				end
				S_ADV: begin
					// idle channels keep phase and position
					if (active) begin
						phase_q[ch_q] <= ph_wrap ? 12'd0 : ph_inc;
						pos_q[ch_q]   <= pos_next;
					end
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (active)
						acc_q <= acc_q + prod[wsg_pkg::ACC_W-1:0];
					if (int'(ch_q) == wsg_pkg::CHANNELS - 1) begin
						state_q <= S_MIX;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= S_ADV;
					end
				end
				S_MIX: begin
					if (emit) begin
						pre_q              <= 16'd0;
						res_q.sample_valid <= 1'b1;
						res_q.sample       <= sat;
					end else begin
						pre_q <= pre_inc[15:0];
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// every accepted item leaves the sequencer busy in the cycle after the accept
	`WSG_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "accept left the block idle")
	// each advance step is followed by its multiply step
	`WSG_ASSERT_NEXT(a_adv_then_mul, state_q == S_ADV, state_q == S_MUL, "advance not followed by multiply")
	// a result without a sample carries a zero sample
	`WSG_ASSERT_SAME(a_zero_sample, rsp_valid && !rsp.sample_valid, rsp.sample == 16'sd0, "sample not zero")

endmodule

FILE: tb/tb_wavetable_sound_generator.sv
// self-checking testbench of the wavetable sound generator: directed table, random phases
module tb_wavetable_sound_generator;
	timeunit 1ns;
	timeprecision 1ps;

	// run limits
	localparam int CYCLE_LIMIT = 500000;
	localparam int LONG_HOLD   = 400;
	localparam int END_WAIT    = 20;

	// one row of the directed table; known marks a result typed in by hand
	typedef struct {
		wsg_pkg::req_t item;
		bit            known;
		wsg_pkg::rsp_t out;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	wsg_pkg::req_t        req;
	logic                 rsp_valid;
	logic                 rsp_stall;
	wsg_pkg::rsp_t        rsp;
	logic                 cfg_valid;
	logic                 cfg_ready;
	wsg_pkg::cfg_index_t  cfg_index;
	logic [15:0]          cfg_data;

	// predicted state of the sound generator
	logic [7:0]                wave_regs [256];
	logic [11:0]               voice_phase [wsg_pkg::CHANNELS];
	logic [wsg_pkg::POS_W-1:0] voice_pos [wsg_pkg::CHANNELS];
	int                        voice_level [wsg_pkg::CHANNELS];
	logic [15:0]               prescale;
	logic [15:0]               divider;
	logic [6:0]                gain;

	// results owed by the block, oldest first
	wsg_pkg::rsp_t owed_outputs [$];
	dir_row_t      directed [$];

	int  errors;
	int  cycle_count;
	bit  no_idle;
	bit  hold_request;

	wavetable_sound_generator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop if the block hangs
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// 0x90-0x9f land on the control bytes
	function automatic logic [7:0] fold_mirror(input logic [7:0] a);
		if (a >= wsg_pkg::MIRROR_LO && a <= wsg_pkg::MIRROR_HI)
			return a - 8'(wsg_pkg::MIRROR_OFS);
		return a;
	endfunction

	// first byte of a channel's waveform; the last channel shares the last waveform
	function automatic int wave_base(input int ch);
		int w;
		w = (ch >= wsg_pkg::CHANNELS - 1) ? wsg_pkg::WAVEFORMS - 1 : ch;
		if (w > wsg_pkg::WAVEFORMS - 1)
			w = wsg_pkg::WAVEFORMS - 1;
		return w * wsg_pkg::WAVE_LENGTH;
	endfunction

	// one tick of all channels: phase count, position step, level
	function automatic void advance_voices();
		logic [4:0]  en;
		logic [11:0] period;
		logic [3:0]  vol;
		logic [7:0]  idx;
		int          s;
		en = wave_regs[wsg_pkg::ENABLE_ADDR][4:0];
		for (int ch = 0; ch < wsg_pkg::CHANNELS; ch++) begin
			period = {wave_regs[wsg_pkg::PERIOD_BASE + 2 * ch + 1][3:0],
				wave_regs[wsg_pkg::PERIOD_BASE + 2 * ch]};
			vol = wave_regs[wsg_pkg::VOLUME_BASE + ch][3:0];
			// idle channel keeps phase and position, level drops to zero
			if (!en[ch] || vol == 4'd0 || period == 12'd0) begin
				voice_level[ch] = 0;
			end else begin
				voice_phase[ch] = voice_phase[ch] + 12'd1;
				// also catches a period lowered below the running count
				if (voice_phase[ch] >= period) begin
					voice_phase[ch] = '0;
					voice_pos[ch] = voice_pos[ch] + 1'b1;
				end
				idx = 8'(wave_base(ch) + int'(voice_pos[ch]));
				s = int'(wave_regs[idx]);
				if (s >= 128)
					s -= 256;
				voice_level[ch] = s * int'(vol);
			end
		end
	endfunction

	// expected result of one accepted item, updates the predicted state
	function automatic wsg_pkg::rsp_t run_sound_item(input wsg_pkg::req_t r);
		wsg_pkg::rsp_t o;
		int            mix;
		int            count;
		o = '0;
		case (r.cmd)
			wsg_pkg::CMD_WRITE: wave_regs[fold_mirror(r.address)] = r.write_data;
			wsg_pkg::CMD_READ:  o.read_data = wave_regs[fold_mirror(r.address)];
			wsg_pkg::CMD_TICK: begin
				advance_voices();
				count = int'(prescale) + 1;
				// a zero divider behaves like one
				if (count >= int'(divider)) begin
					prescale = '0;
					mix = 0;
					for (int ch = 0; ch < wsg_pkg::CHANNELS; ch++)
						mix += voice_level[ch];
					mix *= int'(gain);
					if (mix < wsg_pkg::SAMPLE_MIN)
						mix = wsg_pkg::SAMPLE_MIN;
					if (mix > wsg_pkg::SAMPLE_MAX)
						mix = wsg_pkg::SAMPLE_MAX;
					o.sample_valid = 1'b1;
					o.sample = 16'(mix);
				end else begin
					prescale = 16'(count);
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic int idle_cycles();
		return no_idle ? 0 : $urandom_range(0, 6);
	endfunction

	// random item, mostly well-formed channel setup and ticks
	function automatic wsg_pkg::req_t random_item();
		wsg_pkg::req_t r;
		int            pick;
		int            sel;
		logic [7:0]    a;
		r.cmd = wsg_pkg::CMD_TICK;
		r.address = 8'($urandom);
		r.write_data = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			r.cmd = wsg_pkg::CMD_TICK;
		end else if (pick < 85) begin
			r.cmd = wsg_pkg::CMD_WRITE;
			sel = $urandom_range(0, 9);
			if (sel < 4) begin
				// waveform byte
				r.address = 8'($urandom_range(0, wsg_pkg::PERIOD_BASE - 1));
			end else if (sel < 8) begin
				// control byte, direct or mirrored
				r.address = 8'($urandom_range(wsg_pkg::PERIOD_BASE, wsg_pkg::MIRROR_HI));
				a = fold_mirror(r.address);
				// short periods so that positions move
				if (a < wsg_pkg::VOLUME_BASE && !a[0] && $urandom_range(0, 9) != 0)
					r.write_data = 8'($urandom_range(1, 6));
				else if (a < wsg_pkg::VOLUME_BASE && a[0] && $urandom_range(0, 4) != 0)
					r.write_data = {4'($urandom), 4'h0};
			end
		end else if (pick < 97) begin
			r.cmd = wsg_pkg::CMD_READ;
		end else begin
			r.cmd = wsg_pkg::CMD_NONE;
		end
		return r;
	endfunction

	task automatic add_row(input wsg_pkg::cmd_t c, input int a, input int d, input bit known,
			input int rd, input bit sv, input int smp);
		dir_row_t row;
		row.item.cmd = c;
		row.item.address = 8'(a);
		row.item.write_data = 8'(d);
		row.known = known;
		row.out.read_data = 8'(rd);
		row.out.sample_valid = sv;
		row.out.sample = 16'(smp);
		directed = {directed, row};
	endtask

	// offer one item after a random gap and log what it must produce
	task automatic issue(input wsg_pkg::req_t r, input bit known,
			input wsg_pkg::rsp_t known_out);
		int            gap;
		wsg_pkg::rsp_t predicted;
		gap = idle_cycles();
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		predicted = run_sound_item(r);
		owed_outputs = {owed_outputs, (known ? known_out : predicted)};
	endtask

	// stop offering and wait until every owed result is out
	task automatic drain_outputs();
		@(negedge clk);
		req_valid <= 1'b0;
		while (owed_outputs.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_setting(input wsg_pkg::cfg_index_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == wsg_pkg::CFG_CLOCK_DIVIDER)
			divider = val;
		else
			gain = val[6:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one setting of divider and gain, then random traffic
	task automatic run_phase(input logic [15:0] div, input logic [6:0] gn, input int count,
			input bit hold_test, input bit pause_test);
		drain_outputs();
		write_setting(wsg_pkg::CFG_CLOCK_DIVIDER, div);
		write_setting(wsg_pkg::CFG_OUTPUT_GAIN, {9'd0, gn});
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			// receiver holds off while items keep coming back to back
			if (hold_test && i >= 20 && i < 100)
				no_idle = 1'b1;
			if (hold_test && i == 20)
				hold_request = 1'b1;
			// sender waits for the block to empty mid phase
			if (pause_test && i == count / 2)
				drain_outputs();
			issue(random_item(), 1'b0, '0);
		end
	endtask

	// result side: random stall per item, compare with the oldest owed result
	initial begin
		int            wait_left;
		wsg_pkg::rsp_t want;
		wait_left = 0;
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				if (owed_outputs.size() == 0) begin
					$display("%0t: unexpected item read_data=%h sample_valid=%b sample=%0d",
						$time, rsp.read_data, rsp.sample_valid, $signed(rsp.sample));
					errors++;
				end else begin
					want = owed_outputs.pop_front();
					if (rsp.read_data !== want.read_data) begin
						$display("%0t: read_data expected %h got %h",
							$time, want.read_data, rsp.read_data);
						errors++;
					end
					if (rsp.sample_valid !== want.sample_valid) begin
						$display("%0t: sample_valid expected %b got %b",
							$time, want.sample_valid, rsp.sample_valid);
						errors++;
					end
					if (rsp.sample !== want.sample) begin
						$display("%0t: sample expected %0d got %0d",
							$time, $signed(want.sample), $signed(rsp.sample));
						errors++;
					end
				end
				wait_left = idle_cycles();
			end
			if (hold_request) begin
				hold_request = 1'b0;
				wait_left = LONG_HOLD;
			end
			@(negedge clk);
			rsp_stall <= (wait_left > 0);
			if (wait_left > 0)
				wait_left--;
		end
	end

	// main sequence: reset, directed table, random phases, end check
	initial begin
		errors = 0;
		cycle_count = 0;
		no_idle = 1'b0;
		hold_request = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = wsg_pkg::CFG_CLOCK_DIVIDER;
		cfg_data = '0;
		for (int i = 0; i < 256; i++)
			wave_regs[i] = '0;
		for (int ch = 0; ch < wsg_pkg::CHANNELS; ch++) begin
			voice_phase[ch] = '0;
			voice_pos[ch] = '0;
			voice_level[ch] = 0;
		end
		prescale = '0;
		divider = 16'd1;
		gain = 7'd1;

		// after reset: empty register file, divider and gain of one
		add_row(wsg_pkg::CMD_READ,  'hFF, 'hFF, 1, 'h00, 0, 0);
		// nothing enabled: a zero sample on every tick
		add_row(wsg_pkg::CMD_TICK,  'h00, 'h00, 1, 'h00, 1, 0);
		// unused command changes nothing
		add_row(wsg_pkg::CMD_NONE,  'hFF, 'hFF, 1, 'h00, 0, 0);
		add_row(wsg_pkg::CMD_WRITE, 'h01, 'h80, 1, 'h00, 0, 0);
		add_row(wsg_pkg::CMD_WRITE, 'h02, 'h7F, 1, 'h00, 0, 0);
		add_row(wsg_pkg::CMD_WRITE, 'hFF, 'hFF, 1, 'h00, 0, 0);
		add_row(wsg_pkg::CMD_READ,  'hFF, 'h00, 1, 'hFF, 0, 0);
		// channel 0 set up through the mirror window
		add_row(wsg_pkg::CMD_WRITE, 'h9A, 'hFF, 1, 'h00, 0, 0);
		add_row(wsg_pkg::CMD_WRITE, 'h90, 'h01, 1, 'h00, 0, 0);
		// only the low nibble of the high period byte counts, all of it reads back
		add_row(wsg_pkg::CMD_WRITE, 'h81, 'hF0, 1, 'h00, 0, 0);
		add_row(wsg_pkg::CMD_READ,  'h91, 'h00, 1, 'hF0, 0, 0);
		add_row(wsg_pkg::CMD_WRITE, 'h8F, 'hE1, 1, 'h00, 0, 0);
		add_row(wsg_pkg::CMD_READ,  'h9F, 'h00, 1, 'hE1, 0, 0);
		// most negative and most positive wave bytes at full volume
		add_row(wsg_pkg::CMD_TICK,  'h00, 'h00, 0, 0, 0, 0);
		add_row(wsg_pkg::CMD_TICK,  'h00, 'h00, 0, 0, 0, 0);
		// longest period, two ticks of counting, then period cut below the count
		add_row(wsg_pkg::CMD_WRITE, 'h81, 'h0F, 1, 'h00, 0, 0);
		add_row(wsg_pkg::CMD_WRITE, 'h80, 'hFF, 1, 'h00, 0, 0);
		add_row(wsg_pkg::CMD_TICK,  'h00, 'h00, 0, 0, 0, 0);
		add_row(wsg_pkg::CMD_TICK,  'h00, 'h00, 0, 0, 0, 0);
		add_row(wsg_pkg::CMD_WRITE, 'h81, 'h00, 1, 'h00, 0, 0);
		add_row(wsg_pkg::CMD_WRITE, 'h80, 'h01, 1, 'h00, 0, 0);
		add_row(wsg_pkg::CMD_TICK,  'h00, 'h00, 0, 0, 0, 0);
		// last channel plays the last waveform, channel 0 now disabled
		add_row(wsg_pkg::CMD_WRITE, 'h61, 'h80, 1, 'h00, 0, 0);
		add_row(wsg_pkg::CMD_WRITE, 'h88, 'h01, 1, 'h00, 0, 0);
		add_row(wsg_pkg::CMD_WRITE, 'h9E, 'h0F, 1, 'h00, 0, 0);
		add_row(wsg_pkg::CMD_WRITE, 'h8F, 'h10, 1, 'h00, 0, 0);
		add_row(wsg_pkg::CMD_TICK,  'h00, 'h00, 0, 0, 0, 0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			issue(directed[i].item, directed[i].known, directed[i].out);

		// zero divider, gain 64: heavy clipping
		run_phase(16'd0, 7'd64, 180, 1'b0, 1'b0);
		// zero gain: every sample is zero
		run_phase(16'd1, 7'd0, 150, 1'b0, 1'b1);
		run_phase(16'd3, 7'd63, 180, 1'b0, 1'b1);
		// largest divider: the prescaler only counts
		run_phase(16'hFFFF, 7'd1, 100, 1'b0, 1'b0);
		run_phase(16'd2, 7'd32, 200, 1'b1, 1'b0);
		repeat (2)
			run_phase(16'($urandom_range(1, 8)), 7'($urandom_range(1, 64)), 200, 1'b0, 1'b0);

		drain_outputs();
		repeat (END_WAIT) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
